[hw/rtl/gtnp_pkg.sv]
package gtnp_pkg;

   // width of the stored trigger times and of the elapsed-time arithmetic
   localparam int TimeBits = 32;

   localparam int NumSrc = 5;
   localparam int NumSlots = 2 * NumSrc;
   localparam int SlotBits = $clog2(NumSlots);

   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits = 16;

   localparam logic [CsrIndexBits-1:0] CsrDeadzone      = 2'd0;
   localparam logic [CsrIndexBits-1:0] CsrPulseDuration = 2'd1;
   localparam logic [CsrIndexBits-1:0] CsrPulseInterval = 2'd2;

   localparam logic [6:0]  DeadzoneReset      = 7'd8;
   localparam logic [15:0] PulseDurationReset = 16'd50;
   localparam logic [15:0] PulseIntervalReset = 16'd200;

   // event codes
   localparam logic [3:0] EvUp        = 4'd0;
   localparam logic [3:0] EvDown      = 4'd1;
   localparam logic [3:0] EvLeft      = 4'd2;
   localparam logic [3:0] EvRight     = 4'd3;
   localparam logic [3:0] EvRightBase = 4'd4;
   localparam logic [3:0] EvLeftTrig  = 4'd8;
   localparam logic [3:0] EvRightTrig = 4'd9;
   localparam logic [3:0] EvExtra     = 4'd10;
   localparam logic [3:0] EvNone      = 4'd15;

   localparam logic [6:0] NoteBase = 7'd30;
   localparam logic [6:0] NoteMax  = 7'd40;
   localparam logic [6:0] VelOn    = 7'd127;
   localparam logic [6:0] VelOff   = 7'd0;

   localparam logic [8:0] StickCenter = 9'd128;
   localparam logic [7:0] ExtraIdleLo = 8'h0F;
   localparam logic [7:0] ExtraIdleHi = 8'h00;

   typedef struct packed {
      logic [7:0]  left_x;
      logic [7:0]  left_y;
      logic [7:0]  right_x;
      logic [7:0]  right_y;
      logic [7:0]  extra_lo;
      logic [7:0]  extra_hi;
      logic [7:0]  right_trigger;
      logic [7:0]  left_trigger;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       note_on;
      logic [6:0] note;
      logic [6:0] velocity;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       note_on;
      logic [6:0] note;
   } msg_type;

   // what one lane found for one report: an optional note-off, then an optional note-on
   typedef struct packed {
      logic       off_valid;
      logic [6:0] off_note;
      logic       on_valid;
      logic [6:0] on_note;
   } lane_out_type;

endpackage

[hw/rtl/gtnp_lane.sv]
module gtnp_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [3:0]                    ev,
   input  logic [gtnp_pkg::TimeBits-1:0] now,
   input  logic [15:0]                   duration,
   input  logic [15:0]                   interval,
   output gtnp_pkg::lane_out_type        lane_out
);

   logic [3:0]                    event_ff, event_in;
   logic                          sounding_ff, sounding_in;
   logic [6:0]                    note_ff, note_in;
   logic [gtnp_pkg::TimeBits-1:0] trig_ff, trig_in;

   logic [gtnp_pkg::TimeBits-1:0] elapsed;
   logic [6:0]                    new_note;
   logic                          off_v;
   logic                          on_v;
   logic                          still_on;

   assign elapsed  = now - trig_ff;
   assign new_note = gtnp_pkg::NoteBase + {3'b000, ev};

   always_comb begin
      off_v    = 1'b0;
      on_v     = 1'b0;
      still_on = sounding_ff;
      if (ev != event_ff) begin
         off_v = sounding_ff;
         on_v  = (ev != gtnp_pkg::EvNone);
      end else if (ev != gtnp_pkg::EvNone) begin
         off_v    = sounding_ff && (elapsed >= gtnp_pkg::TimeBits'(duration));
         still_on = sounding_ff && !off_v;
         on_v     = !still_on && (elapsed >= gtnp_pkg::TimeBits'(interval));
      end

      event_in    = event_ff;
      sounding_in = sounding_ff;
      note_in     = note_ff;
      trig_in     = trig_ff;
      if (step) begin
         event_in = ev;
         if (on_v) begin
            sounding_in = 1'b1;
            note_in     = new_note;
            trig_in     = now;
         end else if (off_v) begin
            sounding_in = 1'b0;
         end else if (ev != event_ff) begin
            // change to neutral with nothing sounding
            sounding_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_ff    <= gtnp_pkg::EvNone;
         sounding_ff <= 1'b0;
         note_ff     <= '0;
         trig_ff     <= '0;
      end else begin
         event_ff    <= event_in;
         sounding_ff <= sounding_in;
         note_ff     <= note_in;
         trig_ff     <= trig_in;
      end
   end

   assign lane_out.off_valid = off_v;
   assign lane_out.off_note  = note_ff;
   assign lane_out.on_valid  = on_v;
   assign lane_out.on_note   = new_note;

endmodule

[hw/rtl/gtnp_merge.sv]
module gtnp_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  gtnp_pkg::lane_out_type lane_out [gtnp_pkg::NumSrc],
   output logic                   ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gtnp_pkg::rsp_type      rsp_data
);

   gtnp_pkg::msg_type               slots_ff [gtnp_pkg::NumSlots];
   logic [gtnp_pkg::NumSlots-1:0]   pend_ff, pend_in;
   logic                            out_valid_ff, out_valid_in;
   gtnp_pkg::rsp_type               out_ff;

   logic [gtnp_pkg::SlotBits-1:0]   sel;
   logic [gtnp_pkg::NumSlots-1:0]   rest;
   logic [gtnp_pkg::NumSlots-1:0]   batch_valid;
   logic                            pop;

   // lowest pending slot goes out first: source order, off before on
   always_comb begin
      sel = '0;
      for (int i = gtnp_pkg::NumSlots - 1; i >= 0; i--) begin
         if (pend_ff[i]) sel = gtnp_pkg::SlotBits'(i);
      end
      rest = pend_ff & ~(gtnp_pkg::NumSlots'(1) << sel);
   end

   always_comb begin
      for (int i = 0; i < gtnp_pkg::NumSrc; i++) begin
         batch_valid[2*i]   = lane_out[i].off_valid;
         batch_valid[2*i+1] = lane_out[i].on_valid;
      end
   end

   assign pop   = (|pend_ff) && (!out_valid_ff || !rsp_stall);
   assign ready = (pend_ff == '0) || (pop && (rest == '0));

   always_comb begin
      pend_in = pend_ff;
      if (load) pend_in = batch_valid;
      else if (pop) pend_in = rest;

      out_valid_in = out_valid_ff;
      if (pop) out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < gtnp_pkg::NumSrc; i++) begin
            slots_ff[2*i]   <= '{note_on: 1'b0, note: lane_out[i].off_note};
            slots_ff[2*i+1] <= '{note_on: 1'b1, note: lane_out[i].on_note};
         end
      end
      if (pop) begin
         out_ff.note_on  <= slots_ff[sel].note_on;
         out_ff.note     <= slots_ff[sel].note;
         out_ff.velocity <= slots_ff[sel].note_on ? gtnp_pkg::VelOn : gtnp_pkg::VelOff;
         out_ff.last     <= (rest == '0);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[hw/rtl/gamepad_to_note_pulser.sv]
// the first note message of a report passes the input register, the merge slots and the output register
// throughput: one note message per cycle from the output register while rsp_stall is low; a report
// with up to 10 messages holds the lane stage until the merge pops its last pending message
// five source lanes update their state when the merge loads their messages
// reset: synchronous, all sources inactive with no note sounding, registers at defaults
module gamepad_to_note_pulser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gtnp_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gtnp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [gtnp_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [gtnp_pkg::CsrDataBits-1:0]    csr_data
);

   logic [6:0]  deadzone_ff;
   logic [15:0] duration_ff;
   logic [15:0] interval_ff;

   logic                          in_valid_ff, in_valid_in;
   logic [3:0]                    ev_ff [gtnp_pkg::NumSrc];
   logic [gtnp_pkg::TimeBits-1:0] now_ff;

   logic [3:0]                    ev_in [gtnp_pkg::NumSrc];
   logic [gtnp_pkg::TimeBits-1:0] now_in;
   logic [gtnp_pkg::TimeBits+31:0] now_wide;
   logic [3:0]                    dir_l;
   logic [3:0]                    dir_r;

   logic accept;
   logic fire;
   logic merge_ready;

   gtnp_pkg::lane_out_type lane_out [gtnp_pkg::NumSrc];

   function automatic logic [3:0] stick_dir(input logic [7:0] x, input logic [7:0] y,
                                            input logic [6:0] dz);
      logic [8:0] lo;
      logic [8:0] hi;
      lo = gtnp_pkg::StickCenter - {2'b00, dz};
      hi = gtnp_pkg::StickCenter + {2'b00, dz};
      // x is tested before y
      if ({1'b0, x} < lo) return gtnp_pkg::EvLeft;
      else if ({1'b0, x} > hi) return gtnp_pkg::EvRight;
      else if ({1'b0, y} < lo) return gtnp_pkg::EvUp;
      else if ({1'b0, y} > hi) return gtnp_pkg::EvDown;
      else return gtnp_pkg::EvNone;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= gtnp_pkg::DeadzoneReset;
         duration_ff <= gtnp_pkg::PulseDurationReset;
         interval_ff <= gtnp_pkg::PulseIntervalReset;
      end else if (csr_write) begin
         unique case (csr_index)
            gtnp_pkg::CsrDeadzone:      deadzone_ff <= csr_data[6:0];
            gtnp_pkg::CsrPulseDuration: duration_ff <= csr_data[15:0];
            gtnp_pkg::CsrPulseInterval: interval_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // input stage decodes the report into event codes
   always_comb begin
      dir_l = stick_dir(req_data.left_x, req_data.left_y, deadzone_ff);
      dir_r = stick_dir(req_data.right_x, req_data.right_y, deadzone_ff);
      ev_in[0] = dir_l;
      ev_in[1] = (dir_r == gtnp_pkg::EvNone) ? gtnp_pkg::EvNone
                                             : dir_r + gtnp_pkg::EvRightBase;
      ev_in[2] = (req_data.left_trigger != 8'h00) ? gtnp_pkg::EvLeftTrig
                                                  : gtnp_pkg::EvNone;
      ev_in[3] = (req_data.right_trigger != 8'h00) ? gtnp_pkg::EvRightTrig
                                                   : gtnp_pkg::EvNone;
      ev_in[4] = (req_data.extra_lo != gtnp_pkg::ExtraIdleLo ||
                  req_data.extra_hi != gtnp_pkg::ExtraIdleHi) ? gtnp_pkg::EvExtra
                                                              : gtnp_pkg::EvNone;
      now_wide = {gtnp_pkg::TimeBits'(0), req_data.now_ms};
      now_in   = now_wide[gtnp_pkg::TimeBits-1:0];
   end

   assign fire      = in_valid_ff && merge_ready;
   assign req_stall = in_valid_ff && !merge_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ev_ff  <= ev_in;
         now_ff <= now_in;
      end
   end

   for (genvar s = 0; s < gtnp_pkg::NumSrc; s++) begin : g_lane
      gtnp_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .step     (fire),
         .ev       (ev_ff[s]),
         .now      (now_ff),
         .duration (duration_ff),
         .interval (interval_ff),
         .lane_out (lane_out[s])
      );
   end

   gtnp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .lane_out  (lane_out),
      .ready     (merge_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/gtnp_checker.sv]
module gtnp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input gtnp_pkg::rsp_type                   rsp_data
);

   // nothing comes out in the cycle after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.velocity ==
                    (rsp_data.note_on ? gtnp_pkg::VelOn : gtnp_pkg::VelOff))
      else $error("velocity does not match message kind");

   a_note_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.note >= gtnp_pkg::NoteBase &&
                    rsp_data.note <= gtnp_pkg::NoteMax)
      else $error("note outside the event note range");

   // messages of one report leave without gaps
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid)
      else $error("gap inside the messages of one report");

endmodule

bind gamepad_to_note_pulser gtnp_checker u_gtnp_checker (.*);
